### rtl/prtt_pkg.sv
// Package for the pending request timeout table.
// Holds sizes, action and event codes, and the transfer structs used by every module but prtt_ram.
package prtt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TAG_W       = 32;
    localparam int TIME_W      = 16;
    localparam int ENTRY_W     = TAG_W + TIME_W;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 16'd10;
    localparam logic              REG_TIMEOUT   = 1'b0;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_RESP  = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        EV_ADDED     = 3'd0,
        EV_DUPLICATE = 3'd1,
        EV_FULL      = 3'd2,
        EV_DELIVERED = 3'd3,
        EV_UNMATCHED = 3'd4,
        EV_TIMEOUT   = 3'd5
    } t_event;

    typedef struct packed {
        t_action           action;
        logic [TAG_W-1:0]  serial_tag;
    } t_in_item;

    typedef struct packed {
        t_event            event_kind;
        logic [TAG_W-1:0]  event_tag;
        logic              last_event;
    } t_out_item;

    // one result handed from the engine to the output register
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_evt_push;

endpackage

### rtl/prtt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module prtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/prtt_cmp.sv
// Shared compare unit: tag match for add/response, age check for tick.
// Depends on prtt_pkg for field widths.
module prtt_cmp
    import prtt_pkg::*;
(
    input  logic              i_age_mode,
    input  logic              i_slot_valid,
    input  logic [TAG_W-1:0]  i_key_tag,
    input  logic [TAG_W-1:0]  i_slot_tag,
    input  logic [TIME_W-1:0] i_time_now,
    input  logic [TIME_W-1:0] i_start,
    input  logic [TIME_W-1:0] i_timeout,
    output logic              o_hit
);

    logic [TIME_W-1:0] age;

    // age wraps with the time counter
    assign age   = i_time_now - i_start;
    assign o_hit = i_slot_valid && (i_age_mode ? (age >= i_timeout)
                                               : (i_key_tag == i_slot_tag));

endmodule

### rtl/prtt_engine.sv
// Sequencer walking the table one slot per cycle via the shared compare unit, unless a tick stalls on output.
// Depends on prtt_pkg, prtt_ram and prtt_cmp.
module prtt_engine
    import prtt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_in_item          i_item,
    output logic              o_busy,
    input  logic [TIME_W-1:0] i_timeout,
    input  logic              i_out_free,
    output t_evt_push         o_push
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    t_state                  r_state, n_state;
    logic [IDX_W-1:0]        r_idx, n_idx;
    t_action                 r_act, n_act;
    logic [TAG_W-1:0]        r_tag, n_tag;
    logic [TIME_W-1:0]       r_time, n_time;
    logic [TABLE_DEPTH-1:0]  r_slot_valid, n_slot_valid;
    logic                    r_hit, n_hit;
    logic [IDX_W-1:0]        r_hit_idx, n_hit_idx;
    logic                    r_free_found, n_free_found;
    logic [IDX_W-1:0]        r_free_idx, n_free_idx;
    logic                    r_held_valid, n_held_valid;
    logic [TAG_W-1:0]        r_held_tag, n_held_tag;

    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic [ENTRY_W-1:0]      wdata;
    logic [ENTRY_W-1:0]      rdata;
    logic [TAG_W-1:0]        rd_tag;
    logic [TIME_W-1:0]       rd_start;
    logic                    cur_valid;
    logic                    slot_hit;
    logic                    advance;
    t_evt_push               push;

    // read address follows the next index so data for r_idx is ready in ST_SCAN
    prtt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (IDX_W)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (n_idx),
        .o_rdata (rdata)
    );

    assign rd_tag    = rdata[ENTRY_W-1:TIME_W];
    assign rd_start  = rdata[TIME_W-1:0];
    assign cur_valid = r_slot_valid[r_idx];

    prtt_cmp u_cmp (
        .i_age_mode   (r_act == ACT_TICK),
        .i_slot_valid (cur_valid),
        .i_key_tag    (r_tag),
        .i_slot_tag   (rd_tag),
        .i_time_now   (r_time),
        .i_start      (rd_start),
        .i_timeout    (i_timeout),
        .o_hit        (slot_hit)
    );

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_act        = r_act;
        n_tag        = r_tag;
        n_time       = r_time;
        n_slot_valid = r_slot_valid;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_held_valid = r_held_valid;
        n_held_tag   = r_held_tag;
        we           = 1'b0;
        waddr        = r_free_idx;
        wdata        = {r_tag, r_time};
        push         = '0;
        advance      = 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_item.action == ACT_CLEAR) begin
                        n_slot_valid = '0;
                    end else begin
                        n_act        = i_item.action;
                        n_tag        = i_item.serial_tag;
                        n_idx        = '0;
                        n_hit        = 1'b0;
                        n_free_found = 1'b0;
                        n_held_valid = 1'b0;
                        n_state      = ST_SCAN;
                        if (i_item.action == ACT_TICK) begin
                            n_time = r_time + 1'b1;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (r_act == ACT_TICK) begin
                    if (slot_hit) begin
                        // hold the newest expiry; the previous one is now known not last
                        if (r_held_valid && !i_out_free) begin
                            advance = 1'b0;
                        end else begin
                            if (r_held_valid) begin
                                push.valid           = 1'b1;
                                push.item.event_kind = EV_TIMEOUT;
                                push.item.event_tag  = r_held_tag;
                                push.item.last_event = 1'b0;
                            end
                            n_held_valid        = 1'b1;
                            n_held_tag          = rd_tag;
                            n_slot_valid[r_idx] = 1'b0;
                        end
                    end
                end else begin
                    if (!cur_valid && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_idx;
                    end
                    if (slot_hit) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_idx;
                        n_state   = ST_DONE;
                        advance   = 1'b0;
                    end
                end
                if (advance) begin
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_DONE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                case (r_act)
                    ACT_ADD: begin
                        if (i_out_free) begin
                            push.valid           = 1'b1;
                            push.item.event_tag  = r_tag;
                            push.item.last_event = 1'b1;
                            if (r_hit) begin
                                push.item.event_kind = EV_DUPLICATE;
                            end else if (r_free_found) begin
                                push.item.event_kind     = EV_ADDED;
                                we                       = 1'b1;
                                n_slot_valid[r_free_idx] = 1'b1;
                            end else begin
                                push.item.event_kind = EV_FULL;
                            end
                            n_state = ST_IDLE;
                        end
                    end
                    ACT_RESP: begin
                        if (i_out_free) begin
                            push.valid           = 1'b1;
                            push.item.event_tag  = r_tag;
                            push.item.last_event = 1'b1;
                            if (r_hit) begin
                                push.item.event_kind    = EV_DELIVERED;
                                n_slot_valid[r_hit_idx] = 1'b0;
                            end else begin
                                push.item.event_kind = EV_UNMATCHED;
                            end
                            n_state = ST_IDLE;
                        end
                    end
                    ACT_TICK: begin
                        if (!r_held_valid) begin
                            n_state = ST_IDLE;
                        end else if (i_out_free) begin
                            push.valid           = 1'b1;
                            push.item.event_kind = EV_TIMEOUT;
                            push.item.event_tag  = r_held_tag;
                            push.item.last_event = 1'b1;
                            n_held_valid         = 1'b0;
                            n_state              = ST_IDLE;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_act        <= ACT_ADD;
            r_time       <= '0;
            r_slot_valid <= '0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_held_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_act        <= n_act;
            r_time       <= n_time;
            r_slot_valid <= n_slot_valid;
            r_hit        <= n_hit;
            r_free_found <= n_free_found;
            r_held_valid <= n_held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag      <= n_tag;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_held_tag <= n_held_tag;
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_push = push;

`ifndef SYNTH
    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid |-> i_out_free)
        else $error("result pushed while output register is blocked");

    a_no_push_in_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_act != ACT_TICK) |-> !push.valid)
        else $error("lookup walk produced a result before finishing");

    a_added_writes_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.valid && push.item.event_kind == EV_ADDED) |-> (we && !r_slot_valid[r_free_idx]))
        else $error("added event without writing a free slot");

    a_tick_advances_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_valid && i_item.action == ACT_TICK)
        |=> (r_time == TIME_W'($past(r_time) + 1'b1)))
        else $error("tick did not advance the time counter");

    a_done_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && i_out_free) |=> (r_state == ST_IDLE))
        else $error("sequencer stuck after finishing an item");
`endif

endmodule

### rtl/pending_request_timeout_table.sv
// An add or response walks the table until a hit or the last slot, then its result is
// pushed to the output register from ST_DONE; a tick's timeouts stream out during its walk,
// the last one from ST_DONE; output stalls can hold both; a clear just empties the table.
// A new item is stalled until the last one is through, as the walk is paced by the entry
// RAM with its single registered read port and the one shared compare unit.
// Reset (synchronous, active low) empties the table, zeroes time, sets timeout to 10.
module pending_request_timeout_table
    import prtt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [TIME_W-1:0] r_timeout;
    logic              r_out_valid;
    t_out_item         r_out_data;
    logic              busy;
    logic              out_free;
    t_evt_push         push;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIMEOUT) ? {{(APB_DW-TIME_W){1'b0}}, r_timeout} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_TIMEOUT)) begin
            r_timeout <= pwdata[TIME_W-1:0];
        end
    end

    prtt_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_item     (i_in_data),
        .o_busy     (busy),
        .i_timeout  (r_timeout),
        .i_out_free (out_free),
        .o_push     (push)
    );

    assign o_in_stall = busy;

    // output register: refill in the same cycle the held transfer drains
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push.valid) begin
            r_out_data <= push.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
